[rtl/vgbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgbl_pkg
// shared sizes, codes and sequencer states of the volatility grid lookup
// ----------------------------------------------------------------------------
package vgbl_pkg;

  localparam int MAX_STRIKES  = 32;
  localparam int MAX_EXPIRIES = 16;
  localparam int SIDX_W       = $clog2(MAX_STRIKES);
  localparam int EIDX_W       = $clog2(MAX_EXPIRIES);
  localparam int SCNT_W       = $clog2(MAX_STRIKES + 1);
  localparam int ECNT_W       = $clog2(MAX_EXPIRIES + 1);
  localparam int GADDR_W      = SIDX_W + EIDX_W;
  localparam int GRID_DEPTH   = MAX_STRIKES * MAX_EXPIRIES;
  localparam int SCAN_N       = (MAX_STRIKES > MAX_EXPIRIES) ? MAX_STRIKES : MAX_EXPIRIES;
  localparam int IW           = $clog2(SCAN_N + 1);

  localparam int VOL_W  = 32;
  localparam int PROD_W = 2 * VOL_W;
  localparam int ACC_W  = 100;
  localparam int DCNT_W = $clog2(ACC_W);

  localparam logic [VOL_W-1:0] DEFAULT_VOL_RST = 32'd13107;

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [2:0] REG_DEFAULT_VOL = 3'd0;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FETCH,
    S_DIFF,
    S_WMUL,
    S_TERM,
    S_DIVST,
    S_DIVWAIT,
    S_SAX,
    S_SGRID,
    S_SZERO,
    S_ECHK,
    S_EAX,
    S_EGRID,
    S_EZERO,
    S_WRITE,
    S_DONE
  } state_t;

  function automatic logic [GADDR_W-1:0] gaddr(input logic [SIDX_W-1:0] row,
                                               input logic [EIDX_W-1:0] col);
    gaddr = {row, col};
  endfunction

endpackage

[rtl/vgbl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgbl_div
// restoring divider, one quotient bit a cycle, quotient saturated to 32 bits
// ----------------------------------------------------------------------------
module vgbl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [vgbl_pkg::ACC_W-1:0]    num,
  input  logic [vgbl_pkg::PROD_W-1:0]   den,
  output logic                          done,
  output logic [vgbl_pkg::VOL_W-1:0]    quo
);

  logic [vgbl_pkg::ACC_W-1:0]  num_r, num_nxt;
  logic [vgbl_pkg::PROD_W-1:0] rem_r, rem_nxt;
  logic [vgbl_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [vgbl_pkg::VOL_W-1:0]  q_r, q_nxt;
  logic                        over_r, over_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [vgbl_pkg::PROD_W:0]   r2;
  logic                        ge;

  assign r2 = {rem_r, num_r[vgbl_pkg::ACC_W-1]};
  assign ge = (r2 >= {1'b0, den});

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    over_nxt = over_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = vgbl_pkg::DCNT_W'(vgbl_pkg::ACC_W - 1);
      q_nxt    = '0;
      over_nxt = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? vgbl_pkg::PROD_W'(r2 - {1'b0, den}) : r2[vgbl_pkg::PROD_W-1:0];
      num_nxt = num_r << 1;
      q_nxt   = {q_r[vgbl_pkg::VOL_W-2:0], ge};
      // a quotient bit above bit 31 means the result does not fit
      if (ge && (cnt_r >= vgbl_pkg::DCNT_W'(vgbl_pkg::VOL_W))) begin
        over_nxt = 1'b1;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    q_r    <= q_nxt;
    over_r <= over_nxt;
  end

  assign done = done_r;
  assign quo  = over_r ? '1 : q_r;

endmodule

[rtl/vol_grid_bilinear_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vol_grid_bilinear_lookup
// volatility surface on a sorted strike / expiry grid with bilinear lookup
// ----------------------------------------------------------------------------
// usage
//   in channel: one transfer per request; tuser = mode (0 query, 1 update),
//   tdata = strike, expiry, vol_value. out channel: one transfer per request,
//   tdata = vol_out, tuser = status (0 ok, 1 empty surface, 2 axis full).
//   cfg port: APB write of default_vol at address 0, read back at address 0.
// sequence
//   every request starts with a scan of both axes, one entry a cycle over
//   the axis memories, then a decide step. a query then fetches two values
//   from each axis and four grid cells, runs 13 products through the single
//   shared 32x32 multiplier and a 100-step restoring divide; if the lower
//   cell is on the last strike or expiry that cell is returned instead, and
//   a negative sum returns 0. an update that inserts a strike moves rows one
//   grid cell at a time, a read then a write per cell; an expiry insert moves
//   columns the same way. one request is in flight at a time; in_tready is
//   high only while the sequencer idles.
// reset and stall
//   reset empties both axes and sets default_vol to 0.2; the grid needs no
//   clearing since every cell inside the axis counts is written when its row
//   or column is opened. a result waits in the output register while the
//   receiver stalls, and the next request may be taken meanwhile.
// ----------------------------------------------------------------------------
module vol_grid_bilinear_lookup (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // strike [31:0], expiry [63:32], vol_value [95:64]
  input  logic [0:0]  in_tuser,   // mode [0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // vol_out [31:0]
  output logic [1:0]  out_tuser,  // status [1:0]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW  = vgbl_pkg::SIDX_W;
  localparam int EW  = vgbl_pkg::EIDX_W;
  localparam int SCW = vgbl_pkg::SCNT_W;
  localparam int ECW = vgbl_pkg::ECNT_W;
  localparam int IW  = vgbl_pkg::IW;
  localparam int VW  = vgbl_pkg::VOL_W;
  localparam int PW  = vgbl_pkg::PROD_W;
  localparam int AW  = vgbl_pkg::ACC_W;
  localparam int GW  = vgbl_pkg::GADDR_W;

  vgbl_pkg::state_t state_r, state_nxt;

  // request
  logic          mode_r, mode_nxt;
  logic [VW-1:0] strike_r, strike_nxt, expiry_r, expiry_nxt, vol_r, vol_nxt;

  // surface bookkeeping
  logic [SCW-1:0] scnt_r, scnt_nxt;
  logic [ECW-1:0] ecnt_r, ecnt_nxt;
  logic [VW-1:0]  dflt_r;

  // sequencer counters
  logic [IW-1:0]  i_r, i_nxt;
  logic [ECW-1:0] j_r, j_nxt;
  logic           ph_r, ph_nxt;
  logic [3:0]     k_r, k_nxt;
  logic [IW-1:0]  i_m1;
  logic [ECW-1:0] j_m1;

  // scan results
  logic           chk_r, chk_nxt;
  logic [IW-1:0]  chkidx_r, chkidx_nxt;
  logic [SCW-1:0] lts_r, lts_nxt, les_r, les_nxt;
  logic [ECW-1:0] lte_r, lte_nxt, lee_r, lee_nxt;
  logic [SW-1:0]  s_idx, s_idx1, ps;
  logic [EW-1:0]  e_idx, e_idx1, pe;
  logic           last_c, last_r, last_nxt;
  logic           new_s, new_e;

  // interpolation datapath
  logic [VW-1:0] x1_r, x1_nxt, x2_r, x2_nxt, y1_r, y1_nxt, y2_r, y2_nxt;
  logic [VW-1:0] v_r [4];
  logic [VW-1:0] v_nxt [4];
  logic [VW-1:0] hx_r, hx_nxt, hy_r, hy_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  logic [VW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic          nx_r, nx_nxt, ny_r, ny_nxt;
  logic [PW-1:0] w_r [4];
  logic [PW-1:0] w_nxt [4];
  logic [PW-1:0] den_r, den_nxt;
  logic [VW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          pneg_r, pneg_nxt, phi_r, phi_nxt, pvld_r, pvld_nxt;
  logic [AW-1:0] acc_r, acc_nxt, term_lo, term_c;
  logic          tneg;

  // divider
  logic          div_start, div_done;
  logic [VW-1:0] div_q;

  // result and output register
  logic [VW-1:0] res_vol_r, res_vol_nxt;
  logic [1:0]    res_stat_r, res_stat_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [VW-1:0] out_data_r, out_data_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;

  // memories
  logic [VW-1:0] sax_mem [vgbl_pkg::MAX_STRIKES];
  logic [VW-1:0] eax_mem [vgbl_pkg::MAX_EXPIRIES];
  logic [VW-1:0] grid_mem [vgbl_pkg::GRID_DEPTH];
  logic [VW-1:0] sax_rd_r, eax_rd_r, grid_rd_r;
  logic [SW-1:0] sax_raddr, sax_waddr;
  logic [EW-1:0] eax_raddr, eax_waddr;
  logic [GW-1:0] grid_raddr, grid_waddr;
  logic          sax_we, eax_we, grid_we;
  logic [VW-1:0] sax_wdata, eax_wdata, grid_wdata;

  logic cfg_wr;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr == vgbl_pkg::REG_DEFAULT_VOL) ? dflt_r : '0;

  // ---------------------------------------------------------------------------
  // derived scan values
  // ---------------------------------------------------------------------------
  // lower cell: last entry <= value, or entry 0 below the axis
  assign s_idx  = (les_r == '0) ? '0 : SW'(les_r - 1'b1);
  assign e_idx  = (lee_r == '0) ? '0 : EW'(lee_r - 1'b1);
  assign s_idx1 = s_idx + 1'b1;
  assign e_idx1 = e_idx + 1'b1;
  assign last_c = ((SCW'(s_idx) + 1'b1) >= scnt_r) || ((ECW'(e_idx) + 1'b1) >= ecnt_r);
  // insert position: number of entries below the value
  assign ps     = lts_r[SW-1:0];
  assign pe     = lte_r[EW-1:0];
  // axes are strictly increasing: an equal entry exists iff le > lt
  assign new_s  = (les_r == lts_r);
  assign new_e  = (lee_r == lte_r);
  assign i_m1   = i_r - 1'b1;
  assign j_m1   = j_r - 1'b1;

  // shared multiplier
  assign mul_p = {{VW{1'b0}}, mul_a} * {{VW{1'b0}}, mul_b};

  assign term_lo = AW'(prod_r);
  assign term_c  = phi_r ? (term_lo << VW) : term_lo;

  // sign of each bilinear term: v11 +, v21 by nx, v12 by ny, v22 by both
  always_comb begin
    case (k_r[2:1])
      2'd0:    tneg = 1'b0;
      2'd1:    tneg = nx_r;
      2'd2:    tneg = ny_r;
      default: tneg = nx_r ^ ny_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vgbl_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = vgbl_pkg::S_SCAN;
      end
      vgbl_pkg::S_SCAN: begin
        if (i_r == IW'(vgbl_pkg::SCAN_N)) state_nxt = vgbl_pkg::S_DECIDE;
      end
      vgbl_pkg::S_DECIDE: begin
        if (mode_r == vgbl_pkg::MODE_QUERY) begin
          if ((scnt_r == '0) || (ecnt_r == '0)) state_nxt = vgbl_pkg::S_DONE;
          else                                  state_nxt = vgbl_pkg::S_FETCH;
        end else if ((new_s && (scnt_r == SCW'(vgbl_pkg::MAX_STRIKES))) ||
                     (new_e && (ecnt_r == ECW'(vgbl_pkg::MAX_EXPIRIES)))) begin
          state_nxt = vgbl_pkg::S_DONE;
        end else if (new_s) begin
          state_nxt = vgbl_pkg::S_SAX;
        end else begin
          state_nxt = vgbl_pkg::S_ECHK;
        end
      end
      vgbl_pkg::S_FETCH: begin
        if ((k_r == 4'd3) && last_r) state_nxt = vgbl_pkg::S_DONE;
        else if (k_r == 4'd6)        state_nxt = vgbl_pkg::S_DIFF;
      end
      vgbl_pkg::S_DIFF: state_nxt = vgbl_pkg::S_WMUL;
      vgbl_pkg::S_WMUL: begin
        if (k_r == 4'd4) state_nxt = vgbl_pkg::S_TERM;
      end
      vgbl_pkg::S_TERM: begin
        if (k_r == 4'd8) state_nxt = vgbl_pkg::S_DIVST;
      end
      vgbl_pkg::S_DIVST: begin
        if (acc_r[AW-1]) state_nxt = vgbl_pkg::S_DONE;
        else             state_nxt = vgbl_pkg::S_DIVWAIT;
      end
      vgbl_pkg::S_DIVWAIT: begin
        if (div_done) state_nxt = vgbl_pkg::S_DONE;
      end
      vgbl_pkg::S_SAX: begin
        if (i_r == IW'(lts_r)) state_nxt = vgbl_pkg::S_SGRID;
      end
      vgbl_pkg::S_SGRID: begin
        if (i_r == IW'(lts_r)) state_nxt = vgbl_pkg::S_SZERO;
      end
      vgbl_pkg::S_SZERO: begin
        if (j_r == ecnt_r) state_nxt = vgbl_pkg::S_ECHK;
      end
      vgbl_pkg::S_ECHK: begin
        if (new_e) state_nxt = vgbl_pkg::S_EAX;
        else       state_nxt = vgbl_pkg::S_WRITE;
      end
      vgbl_pkg::S_EAX: begin
        if (j_r == lte_r) state_nxt = vgbl_pkg::S_EGRID;
      end
      vgbl_pkg::S_EGRID: begin
        if (i_r == IW'(scnt_r)) state_nxt = vgbl_pkg::S_EZERO;
      end
      vgbl_pkg::S_EZERO: begin
        if (i_r == IW'(scnt_r)) state_nxt = vgbl_pkg::S_WRITE;
      end
      vgbl_pkg::S_WRITE: state_nxt = vgbl_pkg::S_DONE;
      vgbl_pkg::S_DONE: begin
        if (!out_vld_r || out_tready) state_nxt = vgbl_pkg::S_IDLE;
      end
      default: state_nxt = vgbl_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_nxt     = mode_r;
    strike_nxt   = strike_r;
    expiry_nxt   = expiry_r;
    vol_nxt      = vol_r;
    scnt_nxt     = scnt_r;
    ecnt_nxt     = ecnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    ph_nxt       = ph_r;
    k_nxt        = k_r;
    chk_nxt      = chk_r;
    chkidx_nxt   = chkidx_r;
    lts_nxt      = lts_r;
    les_nxt      = les_r;
    lte_nxt      = lte_r;
    lee_nxt      = lee_r;
    last_nxt     = last_r;
    x1_nxt       = x1_r;
    x2_nxt       = x2_r;
    y1_nxt       = y1_r;
    y2_nxt       = y2_r;
    v_nxt        = v_r;
    hx_nxt       = hx_r;
    hy_nxt       = hy_r;
    ax_nxt       = ax_r;
    ay_nxt       = ay_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    nx_nxt       = nx_r;
    ny_nxt       = ny_r;
    w_nxt        = w_r;
    den_nxt      = den_r;
    prod_nxt     = prod_r;
    pneg_nxt     = pneg_r;
    phi_nxt      = phi_r;
    pvld_nxt     = pvld_r;
    acc_nxt      = acc_r;
    res_vol_nxt  = res_vol_r;
    res_stat_nxt = res_stat_r;
    out_vld_nxt  = out_vld_r & ~out_tready;
    out_data_nxt = out_data_r;
    out_stat_nxt = out_stat_r;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    sax_raddr    = i_r[SW-1:0];
    eax_raddr    = i_r[EW-1:0];
    grid_raddr   = vgbl_pkg::gaddr(s_idx, e_idx);
    sax_we       = 1'b0;
    sax_waddr    = i_r[SW-1:0];
    sax_wdata    = sax_rd_r;
    eax_we       = 1'b0;
    eax_waddr    = j_r[EW-1:0];
    eax_wdata    = eax_rd_r;
    grid_we      = 1'b0;
    grid_waddr   = vgbl_pkg::gaddr(i_r[SW-1:0], j_r[EW-1:0]);
    grid_wdata   = grid_rd_r;

    case (state_r)
      vgbl_pkg::S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_tuser[0];
          strike_nxt = in_tdata[31:0];
          expiry_nxt = in_tdata[63:32];
          vol_nxt    = in_tdata[95:64];
          i_nxt      = '0;
          chk_nxt    = 1'b0;
          lts_nxt    = '0;
          les_nxt    = '0;
          lte_nxt    = '0;
          lee_nxt    = '0;
        end
      end

      // both axes in parallel, compare data arrives the cycle after its address
      vgbl_pkg::S_SCAN: begin
        chk_nxt    = 1'b1;
        chkidx_nxt = i_r;
        i_nxt      = i_r + 1'b1;
        if (chk_r) begin
          if (chkidx_r < IW'(scnt_r)) begin
            if (sax_rd_r < strike_r)  lts_nxt = lts_r + 1'b1;
            if (sax_rd_r <= strike_r) les_nxt = les_r + 1'b1;
          end
          if (chkidx_r < IW'(ecnt_r)) begin
            if (eax_rd_r < expiry_r)  lte_nxt = lte_r + 1'b1;
            if (eax_rd_r <= expiry_r) lee_nxt = lee_r + 1'b1;
          end
        end
      end

      vgbl_pkg::S_DECIDE: begin
        res_vol_nxt  = '0;
        res_stat_nxt = vgbl_pkg::STAT_OK;
        ph_nxt       = 1'b0;
        if (mode_r == vgbl_pkg::MODE_QUERY) begin
          if ((scnt_r == '0) || (ecnt_r == '0)) begin
            res_vol_nxt  = dflt_r;
            res_stat_nxt = vgbl_pkg::STAT_EMPTY;
          end else begin
            last_nxt = last_c;
            k_nxt    = last_c ? 4'd2 : 4'd0;
          end
        end else if ((new_s && (scnt_r == SCW'(vgbl_pkg::MAX_STRIKES))) ||
                     (new_e && (ecnt_r == ECW'(vgbl_pkg::MAX_EXPIRIES)))) begin
          res_stat_nxt = vgbl_pkg::STAT_FULL;
        end else begin
          i_nxt = IW'(scnt_r);
        end
      end

      // axis pair at steps 0-1, grid corners at steps 2-5
      vgbl_pkg::S_FETCH: begin
        sax_raddr = (k_r == 4'd0) ? s_idx : s_idx1;
        eax_raddr = (k_r == 4'd0) ? e_idx : e_idx1;
        case (k_r)
          4'd3:    grid_raddr = vgbl_pkg::gaddr(s_idx, e_idx1);
          4'd4:    grid_raddr = vgbl_pkg::gaddr(s_idx1, e_idx);
          4'd5:    grid_raddr = vgbl_pkg::gaddr(s_idx1, e_idx1);
          default: grid_raddr = vgbl_pkg::gaddr(s_idx, e_idx);
        endcase
        case (k_r)
          4'd1: begin
            x1_nxt = sax_rd_r;
            y1_nxt = eax_rd_r;
          end
          4'd2: begin
            x2_nxt = sax_rd_r;
            y2_nxt = eax_rd_r;
          end
          4'd3: begin
            v_nxt[0]    = grid_rd_r;
            res_vol_nxt = grid_rd_r;
          end
          4'd4:    v_nxt[2] = grid_rd_r;
          4'd5:    v_nxt[1] = grid_rd_r;
          4'd6:    v_nxt[3] = grid_rd_r;
          default: ;
        endcase
        k_nxt = k_r + 1'b1;
      end

      vgbl_pkg::S_DIFF: begin
        nx_nxt = strike_r < x1_r;
        ny_nxt = expiry_r < y1_r;
        hx_nxt = x2_r - strike_r;
        hy_nxt = y2_r - expiry_r;
        ax_nxt = (strike_r < x1_r) ? (x1_r - strike_r) : (strike_r - x1_r);
        ay_nxt = (expiry_r < y1_r) ? (y1_r - expiry_r) : (expiry_r - y1_r);
        dx_nxt = x2_r - x1_r;
        dy_nxt = y2_r - y1_r;
        k_nxt  = '0;
      end

      // corner weights and the cell area through the shared multiplier
      vgbl_pkg::S_WMUL: begin
        case (k_r)
          4'd0: begin
            mul_a = hx_r;
            mul_b = hy_r;
          end
          4'd1: begin
            mul_a = ax_r;
            mul_b = hy_r;
          end
          4'd2: begin
            mul_a = hx_r;
            mul_b = ay_r;
          end
          4'd3: begin
            mul_a = ax_r;
            mul_b = ay_r;
          end
          default: begin
            mul_a = dx_r;
            mul_b = dy_r;
          end
        endcase
        if (k_r == 4'd4) begin
          den_nxt  = mul_p;
          k_nxt    = '0;
          pvld_nxt = 1'b0;
          acc_nxt  = '0;
        end else begin
          w_nxt[k_r[1:0]] = mul_p;
          k_nxt           = k_r + 1'b1;
        end
      end

      // weight halves times corner values, accumulated in the following cycle
      vgbl_pkg::S_TERM: begin
        mul_a    = k_r[0] ? w_r[k_r[2:1]][PW-1:VW] : w_r[k_r[2:1]][VW-1:0];
        mul_b    = v_r[k_r[2:1]];
        prod_nxt = mul_p;
        phi_nxt  = k_r[0];
        pneg_nxt = tneg;
        pvld_nxt = ~k_r[3];
        if (pvld_r) begin
          acc_nxt = pneg_r ? (acc_r - term_c) : (acc_r + term_c);
        end
        k_nxt = k_r + 1'b1;
      end

      vgbl_pkg::S_DIVST: begin
        res_vol_nxt = '0;
        div_start   = ~acc_r[AW-1];
      end

      vgbl_pkg::S_DIVWAIT: begin
        res_vol_nxt = div_q;
      end

      // strike axis moves up one entry from the top down to the insert point
      vgbl_pkg::S_SAX: begin
        if (i_r == IW'(lts_r)) begin
          i_nxt  = IW'(scnt_r);
          j_nxt  = '0;
          ph_nxt = 1'b0;
        end else if (!ph_r) begin
          sax_raddr = i_m1[SW-1:0];
          ph_nxt    = 1'b1;
        end else begin
          sax_we    = 1'b1;
          sax_waddr = i_r[SW-1:0];
          i_nxt     = i_m1;
          ph_nxt    = 1'b0;
        end
      end

      // grid rows follow, only the live columns
      vgbl_pkg::S_SGRID: begin
        if (i_r == IW'(lts_r)) begin
          j_nxt = '0;
        end else if (j_r == ecnt_r) begin
          i_nxt = i_m1;
          j_nxt = '0;
        end else if (!ph_r) begin
          grid_raddr = vgbl_pkg::gaddr(i_m1[SW-1:0], j_r[EW-1:0]);
          ph_nxt     = 1'b1;
        end else begin
          grid_we = 1'b1;
          j_nxt   = j_r + 1'b1;
          ph_nxt  = 1'b0;
        end
      end

      // open row reads zero, new strike lands at the insert point
      vgbl_pkg::S_SZERO: begin
        if (j_r == ecnt_r) begin
          sax_we    = 1'b1;
          sax_waddr = ps;
          sax_wdata = strike_r;
          scnt_nxt  = scnt_r + 1'b1;
        end else begin
          grid_we    = 1'b1;
          grid_waddr = vgbl_pkg::gaddr(ps, j_r[EW-1:0]);
          grid_wdata = '0;
          j_nxt      = j_r + 1'b1;
        end
      end

      vgbl_pkg::S_ECHK: begin
        j_nxt  = ecnt_r;
        ph_nxt = 1'b0;
      end

      vgbl_pkg::S_EAX: begin
        if (j_r == lte_r) begin
          i_nxt  = '0;
          j_nxt  = ecnt_r;
          ph_nxt = 1'b0;
        end else if (!ph_r) begin
          eax_raddr = j_m1[EW-1:0];
          ph_nxt    = 1'b1;
        end else begin
          eax_we = 1'b1;
          j_nxt  = j_m1;
          ph_nxt = 1'b0;
        end
      end

      // every live row shifts its columns above the insert point
      vgbl_pkg::S_EGRID: begin
        if (i_r == IW'(scnt_r)) begin
          i_nxt = '0;
        end else if (j_r == lte_r) begin
          i_nxt = i_r + 1'b1;
          j_nxt = ecnt_r;
        end else if (!ph_r) begin
          grid_raddr = vgbl_pkg::gaddr(i_r[SW-1:0], j_m1[EW-1:0]);
          ph_nxt     = 1'b1;
        end else begin
          grid_we = 1'b1;
          j_nxt   = j_m1;
          ph_nxt  = 1'b0;
        end
      end

      vgbl_pkg::S_EZERO: begin
        if (i_r == IW'(scnt_r)) begin
          eax_we    = 1'b1;
          eax_waddr = pe;
          eax_wdata = expiry_r;
          ecnt_nxt  = ecnt_r + 1'b1;
        end else begin
          grid_we    = 1'b1;
          grid_waddr = vgbl_pkg::gaddr(i_r[SW-1:0], pe);
          grid_wdata = '0;
          i_nxt      = i_r + 1'b1;
        end
      end

      vgbl_pkg::S_WRITE: begin
        grid_we      = 1'b1;
        grid_waddr   = vgbl_pkg::gaddr(ps, pe);
        grid_wdata   = vol_r;
        res_vol_nxt  = vol_r;
        res_stat_nxt = vgbl_pkg::STAT_OK;
      end

      // hand the result to the output register once it is free
      vgbl_pkg::S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_vol_r;
          out_stat_nxt = res_stat_r;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // divider
  // ---------------------------------------------------------------------------
  vgbl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // ---------------------------------------------------------------------------
  // memories, one write and one registered read each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (sax_we) sax_mem[sax_waddr] <= sax_wdata;
    sax_rd_r <= sax_mem[sax_raddr];
  end

  always_ff @(posedge clk) begin
    if (eax_we) eax_mem[eax_waddr] <= eax_wdata;
    eax_rd_r <= eax_mem[eax_raddr];
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    grid_rd_r <= grid_mem[grid_raddr];
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vgbl_pkg::S_IDLE;
      scnt_r    <= '0;
      ecnt_r    <= '0;
      dflt_r    <= vgbl_pkg::DEFAULT_VOL_RST;
      out_vld_r <= 1'b0;
      chk_r     <= 1'b0;
      pvld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scnt_r    <= scnt_nxt;
      ecnt_r    <= ecnt_nxt;
      out_vld_r <= out_vld_nxt;
      chk_r     <= chk_nxt;
      pvld_r    <= pvld_nxt;
      if (cfg_wr && (cfg_paddr == vgbl_pkg::REG_DEFAULT_VOL)) dflt_r <= cfg_pwdata;
    end
    mode_r     <= mode_nxt;
    strike_r   <= strike_nxt;
    expiry_r   <= expiry_nxt;
    vol_r      <= vol_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    ph_r       <= ph_nxt;
    k_r        <= k_nxt;
    chkidx_r   <= chkidx_nxt;
    lts_r      <= lts_nxt;
    les_r      <= les_nxt;
    lte_r      <= lte_nxt;
    lee_r      <= lee_nxt;
    last_r     <= last_nxt;
    x1_r       <= x1_nxt;
    x2_r       <= x2_nxt;
    y1_r       <= y1_nxt;
    y2_r       <= y2_nxt;
    v_r        <= v_nxt;
    hx_r       <= hx_nxt;
    hy_r       <= hy_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    w_r        <= w_nxt;
    den_r      <= den_nxt;
    prod_r     <= prod_nxt;
    pneg_r     <= pneg_nxt;
    phi_r      <= phi_nxt;
    acc_r      <= acc_nxt;
    res_vol_r  <= res_vol_nxt;
    res_stat_r <= res_stat_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_tready  = (state_r == vgbl_pkg::S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule
